>>> rtl/cet_pkg.sv
// ---------------------------------------------------------------------------
// cet_pkg: shared types and codes for the countdown event table
// Entry layout, command and result kind codes, default table depth.
// ---------------------------------------------------------------------------
`default_nettype none

package cet_pkg;

  // Default number of table slots
  localparam int unsigned TABLE_DEPTH_DEF = 16;

  // Command codes
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Result kind codes
  localparam logic [1:0] KIND_ADD_OK    = 2'd0;
  localparam logic [1:0] KIND_ADD_DROP  = 2'd1;
  localparam logic [1:0] KIND_EXPIRED   = 2'd2;
  localparam logic [1:0] KIND_TICK_NONE = 2'd3;

  // One stored event, 56 bits
  typedef struct packed {
    logic [3:0]  x;
    logic [7:0]  y;
    logic [3:0]  z;
    logic [7:0]  etype;
    logic [31:0] count;
  } entry_t;

endpackage

`default_nettype wire

>>> rtl/cet_mem.sv
// ---------------------------------------------------------------------------
// cet_mem: event entry storage
// Single write port, single read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module cet_mem #(
  parameter int unsigned TABLE_DEPTH = cet_pkg::TABLE_DEPTH_DEF,
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire cet_pkg::entry_t wdata,
  input  wire logic            re,
  input  wire logic [AW-1:0]   raddr,
  output cet_pkg::entry_t      rdata
);

  cet_pkg::entry_t mem [TABLE_DEPTH];

  // Write the entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read word
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/cet_walk.sv
// ---------------------------------------------------------------------------
// cet_walk: command sequencer for the countdown event table
// Appends entries on add unless full, walks the table on tick: emits expired entries,
// compacts survivors in place with their count decremented.
// ---------------------------------------------------------------------------
`default_nettype none

module cet_walk #(
  parameter int unsigned TABLE_DEPTH = cet_pkg::TABLE_DEPTH_DEF,
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  // command side
  input  wire logic          start,
  output logic               busy,
  input  wire logic          cmd,
  input  wire logic [3:0]    pos_x,
  input  wire logic [7:0]    pos_y,
  input  wire logic [3:0]    pos_z,
  input  wire logic [7:0]    event_type,
  input  wire logic [31:0]   timeout_ticks,
  // result side
  output logic               valid,
  output logic [1:0]         kind,
  output logic [3:0]         out_x,
  output logic [7:0]         out_y,
  output logic [3:0]         out_z,
  output logic [7:0]         out_type,
  output logic               last,
  // memory port
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output cet_pkg::entry_t    mem_wdata,
  output logic               mem_re,
  output logic [AW-1:0]      mem_raddr,
  input  wire cet_pkg::entry_t mem_rdata
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic [CW-1:0]   keep;
  logic [CW-1:0]   proc;
  logic            pend_valid;
  cet_pkg::entry_t pend;

  logic          accept;
  logic          acc_add;
  logic          acc_tick;
  logic          full;
  logic [CW-1:0] next_idx;
  logic          at_end;
  logic          cur_expired;
  cet_pkg::entry_t add_word;
  cet_pkg::entry_t dec_word;

  logic          valid_next;
  logic [1:0]    kind_next;
  logic [3:0]    out_x_next;
  logic [7:0]    out_y_next;
  logic [3:0]    out_z_next;
  logic [7:0]    out_type_next;
  logic          last_next;

  assign busy     = (state != S_IDLE);
  assign accept   = start && (state == S_IDLE);
  assign acc_add  = accept && (cmd == cet_pkg::CMD_ADD);
  assign acc_tick = accept && (cmd == cet_pkg::CMD_TICK);
  assign full     = (count >= CW'(TABLE_DEPTH));
  assign next_idx = proc + CW'(1);
  assign at_end   = (next_idx == count);
  assign cur_expired = (mem_rdata.count == 32'd0);

  // Build the appended word and the decremented survivor
  always_comb begin
    add_word       = '0;
    add_word.x     = pos_x;
    add_word.y     = pos_y;
    add_word.z     = pos_z;
    add_word.etype = event_type;
    add_word.count = timeout_ticks;
    dec_word       = mem_rdata;
    dec_word.count = mem_rdata.count - 32'd1;
  end

  // Drive the memory port: append on add, compact during the walk
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count[AW-1:0];
    mem_wdata = add_word;
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state)
      S_IDLE: begin
        mem_we = acc_add && !full;
        mem_re = acc_tick && (count != '0);
      end
      S_WALK: begin
        mem_we    = !cur_expired;
        mem_waddr = keep[AW-1:0];
        mem_wdata = dec_word;
        mem_re    = !at_end;
        mem_raddr = next_idx[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  // Sequence commands, hold one expired entry back to mark the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      keep       <= '0;
      proc       <= '0;
      pend_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          keep       <= '0;
          proc       <= '0;
          pend_valid <= 1'b0;
          if (acc_add) begin
            if (!full) begin
              count <= count + CW'(1);
            end
          end else if (acc_tick) begin
            if (count != '0) begin
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (cur_expired) begin
            pend_valid <= 1'b1;
          end else begin
            keep <= keep + CW'(1);
          end
          proc <= next_idx;
          if (at_end) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          count <= keep;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Hold the most recent expired entry
  always_ff @(posedge clk) begin
    if (state == S_WALK && cur_expired) begin
      pend <= mem_rdata;
    end
  end

  // Form the next result word
  always_comb begin
    valid_next    = 1'b0;
    kind_next     = cet_pkg::KIND_TICK_NONE;
    out_x_next    = '0;
    out_y_next    = '0;
    out_z_next    = '0;
    out_type_next = '0;
    last_next     = 1'b1;
    case (state)
      S_IDLE: begin
        valid_next = acc_add || (acc_tick && (count == '0));
        if (acc_add) begin
          kind_next = full ? cet_pkg::KIND_ADD_DROP : cet_pkg::KIND_ADD_OK;
        end
      end
      S_WALK: begin
        // emit the held entry, a newer expired one follows it
        valid_next    = cur_expired && pend_valid;
        kind_next     = cet_pkg::KIND_EXPIRED;
        out_x_next    = pend.x;
        out_y_next    = pend.y;
        out_z_next    = pend.z;
        out_type_next = pend.etype;
        last_next     = 1'b0;
      end
      S_FIN: begin
        valid_next = 1'b1;
        if (pend_valid) begin
          kind_next     = cet_pkg::KIND_EXPIRED;
          out_x_next    = pend.x;
          out_y_next    = pend.y;
          out_z_next    = pend.z;
          out_type_next = pend.etype;
        end
      end
      default: begin
      end
    endcase
  end

  // Register the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    kind     <= kind_next;
    out_x    <= out_x_next;
    out_y    <= out_y_next;
    out_z    <= out_z_next;
    out_type <= out_type_next;
    last     <= last_next;
  end

endmodule

`default_nettype wire

>>> rtl/countdown_event_table_top.sv
// ---------------------------------------------------------------------------
// countdown_event_table_top: ordered table of pending countdown events
// An add leaves busy low and gives one word. A tick of a table holding N
// entries keeps busy high through the walk (one read per cycle through the
// single read port of the entry memory) and a closing state, and gives one
// word per expired entry, oldest first, or one "nothing expired" word; an
// empty table answers a tick without raising busy. Each word is shown for
// exactly one cycle with valid high and cannot be held off, so the receiver
// must take it in that cycle. last marks the final word of a command.
// ---------------------------------------------------------------------------
`default_nettype none

module countdown_event_table_top #(
  parameter int unsigned TABLE_DEPTH = cet_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire logic          cmd,
  input  wire logic [3:0]    pos_x,
  input  wire logic [7:0]    pos_y,
  input  wire logic [3:0]    pos_z,
  input  wire logic [7:0]    event_type,
  input  wire logic [31:0]   timeout_ticks,
  output logic               valid,
  output logic [1:0]         kind,
  output logic [3:0]         out_x,
  output logic [7:0]         out_y,
  output logic [3:0]         out_z,
  output logic [7:0]         out_type,
  output logic               last
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  cet_pkg::entry_t mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  cet_pkg::entry_t mem_rdata;

  // Sequence commands and results
  cet_walk #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_walk (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .pos_z         (pos_z),
    .event_type    (event_type),
    .timeout_ticks (timeout_ticks),
    .valid         (valid),
    .kind          (kind),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_type      (out_type),
    .last          (last),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

  // Store the entries
  cet_mem #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the countdown event table
// Drives add and tick commands through the start/busy handshake, predicts
// every result word from a local copy of the table, and checks each word
// on the valid strobe against the oldest expected word.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int NUM_DIRECTED = 25;
  localparam int NUM_RANDOM   = 500;
  localparam int EXP_DEPTH    = 1024;

  // One result word as the block shows it
  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] x;
    logic [7:0] y;
    logic [3:0] z;
    logic [7:0] etype;
    logic       last;
  } word_t;

  // One command; typed marks a single-word answer that is spelled out here
  typedef struct packed {
    logic        cmd;
    logic [3:0]  x;
    logic [7:0]  y;
    logic [3:0]  z;
    logic [7:0]  etype;
    logic [31:0] ticks;
    logic        typed;
    logic [1:0]  kind;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        cmd = cet_pkg::CMD_ADD;
  logic [3:0]  pos_x = '0;
  logic [7:0]  pos_y = '0;
  logic [3:0]  pos_z = '0;
  logic [7:0]  event_type = '0;
  logic [31:0] timeout_ticks = '0;
  logic        typed_row = 1'b0;
  logic [1:0]  typed_kind = cet_pkg::KIND_ADD_OK;
  wire logic        busy;
  wire logic        valid;
  wire logic [1:0]  kind;
  wire logic [3:0]  out_x;
  wire logic [7:0]  out_y;
  wire logic [3:0]  out_z;
  wire logic [7:0]  out_type;
  wire logic        last;

  // Local copy of the event table
  cet_pkg::entry_t pending_events[cet_pkg::TABLE_DEPTH_DEF];
  int     pending_fill = 0;

  // Expected words, oldest at the read index
  word_t  expected_words[EXP_DEPTH];
  int     exp_wr = 0;
  int     exp_rd = 0;
  word_t  got_word;
  word_t  want_word;
  int     mismatches = 0;
  int     burst_left = 0;
  row_t   directed_rows[NUM_DIRECTED];

  countdown_event_table_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .event_type(event_type),
    .timeout_ticks(timeout_ticks), .valid(valid), .kind(kind),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .out_type(out_type),
    .last(last)
  );

  always #1 clk = ~clk;

  // Append one expected word
  task automatic queue_word(input word_t w);
    expected_words[exp_wr % EXP_DEPTH] = w;
    exp_wr++;
  endtask

  // Apply one accepted command to the local table and queue its words
  task automatic apply_command(input logic c, input logic [3:0] ax, input logic [7:0] ay,
                               input logic [3:0] az, input logic [7:0] at,
                               input logic [31:0] ac, input logic use_typed,
                               input logic [1:0] tkind);
    word_t  w;
    cet_pkg::entry_t e;
    int     keep;
    int     expiring;
    int     fired;
    w = '0;
    w.last = 1'b1;
    if (c == cet_pkg::CMD_ADD) begin
      if (pending_fill >= cet_pkg::TABLE_DEPTH_DEF) begin
        w.kind = cet_pkg::KIND_ADD_DROP;
      end else begin
        e.x = ax;
        e.y = ay;
        e.z = az;
        e.etype = at;
        e.count = ac;
        pending_events[pending_fill] = e;
        pending_fill++;
        w.kind = cet_pkg::KIND_ADD_OK;
      end
      if (use_typed) w.kind = tkind;
      queue_word(w);
    end else begin
      expiring = 0;
      for (int i = 0; i < pending_fill; i++)
        if (pending_events[i].count == 0) expiring++;
      keep = 0;
      fired = 0;
      // Emit zero counts oldest first, age the rest and close up the gaps
      for (int i = 0; i < pending_fill; i++) begin
        e = pending_events[i];
        if (e.count == 0) begin
          fired++;
          w.kind = cet_pkg::KIND_EXPIRED;
          w.x = e.x;
          w.y = e.y;
          w.z = e.z;
          w.etype = e.etype;
          w.last = (fired == expiring);
          queue_word(w);
        end else begin
          e.count = e.count - 1;
          pending_events[keep] = e;
          keep++;
        end
      end
      pending_fill = keep;
      if (expiring == 0) begin
        w = '0;
        w.kind = use_typed ? tkind : cet_pkg::KIND_TICK_NONE;
        w.last = 1'b1;
        queue_word(w);
      end
    end
  endtask

  // Predict on accepted commands, check every shown word
  always @(posedge clk) begin
    if (!rst && start && !busy)
      apply_command(cmd, pos_x, pos_y, pos_z, event_type, timeout_ticks,
                    typed_row, typed_kind);
    if (!rst && valid) begin
      got_word = {kind, out_x, out_y, out_z, out_type, last};
      if (exp_wr == exp_rd) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: kind %0d x %0h y %0h z %0h type %0h last %0d",
                   kind, out_x, out_y, out_z, out_type, last);
      end else begin
        want_word = expected_words[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (got_word !== want_word) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"word mismatch: kind %0d/%0d x %0h/%0h y %0h/%0h z %0h/%0h",
                      " type %0h/%0h last %0d/%0d (exp/got)"},
                     want_word.kind, kind, want_word.x, out_x, want_word.y, out_y,
                     want_word.z, out_z, want_word.etype, out_type, want_word.last, last);
        end
      end
    end
  end

  // Present one command and hold it until the block takes it
  task automatic send_word(input row_t r);
    start <= 1'b1;
    cmd <= r.cmd;
    pos_x <= r.x;
    pos_y <= r.y;
    pos_z <= r.z;
    event_type <= r.etype;
    timeout_ticks <= r.ticks;
    typed_row <= r.typed;
    typed_kind <= r.kind;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Once the current burst is used up, drop start for a random gap, which may be none
  task automatic pace_sender;
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 15);
    end
  endtask

  function automatic row_t make_row(input logic c, input logic [3:0] ax,
                                    input logic [7:0] ay, input logic [3:0] az,
                                    input logic [7:0] at, input logic [31:0] ac,
                                    input logic typed, input logic [1:0] tkind);
    row_t r;
    r.cmd = c;
    r.x = ax;
    r.y = ay;
    r.z = az;
    r.etype = at;
    r.ticks = ac;
    r.typed = typed;
    r.kind = tkind;
    return r;
  endfunction

  initial begin
    row_t r;
    int   pick;
    // Empty table, field extremes, expiry order, a full table and a mass expiry
    directed_rows[0] = make_row(cet_pkg::CMD_TICK, 4'h0, 8'h00, 4'h0, 8'h00, 32'h0, 1'b1,
                                cet_pkg::KIND_TICK_NONE);
    directed_rows[1] = make_row(cet_pkg::CMD_ADD, 4'hF, 8'hFF, 4'hF, 8'hFF, 32'h0, 1'b1,
                                cet_pkg::KIND_ADD_OK);
    directed_rows[2] = make_row(cet_pkg::CMD_ADD, 4'h0, 8'h00, 4'h0, 8'h00, 32'h0, 1'b1,
                                cet_pkg::KIND_ADD_OK);
    directed_rows[3] = make_row(cet_pkg::CMD_ADD, 4'h5, 8'hA5, 4'hA, 8'h5A, 32'h1, 1'b1,
                                cet_pkg::KIND_ADD_OK);
    directed_rows[4] = make_row(cet_pkg::CMD_ADD, 4'hA, 8'h5A, 4'h5, 8'hA5, 32'hFFFF_FFFF,
                                1'b1, cet_pkg::KIND_ADD_OK);
    directed_rows[5] = make_row(cet_pkg::CMD_TICK, 4'h0, 8'h00, 4'h0, 8'h00, 32'h0, 1'b0,
                                cet_pkg::KIND_ADD_OK);
    directed_rows[6] = make_row(cet_pkg::CMD_TICK, 4'hF, 8'hFF, 4'hF, 8'hFF, 32'hFFFF_FFFF,
                                1'b0, cet_pkg::KIND_ADD_OK);
    directed_rows[7] = make_row(cet_pkg::CMD_TICK, 4'h0, 8'h00, 4'h0, 8'h00, 32'h0, 1'b1,
                                cet_pkg::KIND_TICK_NONE);
    for (int i = 8; i < 23; i++)
      directed_rows[i] = make_row(cet_pkg::CMD_ADD, 4'(i), 8'(i * 17), 4'(15 - i),
                                  8'(i * 9), 32'h0, 1'b1, cet_pkg::KIND_ADD_OK);
    directed_rows[23] = make_row(cet_pkg::CMD_ADD, 4'h3, 8'h3C, 4'hC, 8'hC3, 32'h0, 1'b1,
                                 cet_pkg::KIND_ADD_DROP);
    directed_rows[24] = make_row(cet_pkg::CMD_TICK, 4'h0, 8'h00, 4'h0, 8'h00, 32'h0, 1'b0,
                                 cet_pkg::KIND_ADD_OK);

    // Hold reset before the first command
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_word(directed_rows[i]);
      pace_sender();
    end

    // Random commands: mostly short countdowns so entries churn and expire
    for (int i = 0; i < NUM_RANDOM; i++) begin
      r.cmd = ($urandom_range(0, 99) < 38) ? cet_pkg::CMD_TICK : cet_pkg::CMD_ADD;
      r.x = 4'($urandom);
      r.y = 8'($urandom);
      r.z = 4'($urandom);
      r.etype = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 2)
        r.ticks = $urandom;
      else if (pick < 8)
        r.ticks = $urandom_range(0, 40);
      else
        r.ticks = $urandom_range(0, 5);
      r.typed = 1'b0;
      r.kind = cet_pkg::KIND_ADD_OK;
      send_word(r);
      pace_sender();
    end
    start <= 1'b0;

    // Drain outstanding words, then allow the block to settle
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
